[hw/rtl/sphere_grid_point_generator_defines.svh]
// Assertion macros for the sphere grid point generator checker.
`ifndef SPHERE_GRID_POINT_GENERATOR_DEFINES_SVH
`define SPHERE_GRID_POINT_GENERATOR_DEFINES_SVH

// Clocked assertion, off while reset is high.
`define SGP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SGP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/sgp_pkg.sv]
// Types, widths and constants of the sphere grid point generator.
package sgp_pkg;

   localparam int INDEX_BITS    = 10;
   localparam int RADIUS_BITS   = 31;
   localparam int COORD_BITS    = 32;
   localparam int UNIT_BITS     = 32;
   localparam int PHASE_BITS    = 32;
   localparam int DIV_BITS      = PHASE_BITS + 1;
   localparam int DIV_STEP      = 3;
   localparam int DIV_STAGES    = DIV_BITS / DIV_STEP;
   localparam int REM_BITS      = INDEX_BITS + 3;
   localparam int CORDIC_STAGES = 16;
   localparam int CORDIC_BITS   = 33;
   localparam int ANGLE_BITS    = 34;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_X = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_Y = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_Z = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEGMENTS = 3'd4;

   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET   = 31'd65536;
   localparam logic [INDEX_BITS-1:0]  SEGMENTS_RESET = INDEX_BITS'(200);

   localparam logic signed [CORDIC_BITS-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic [PHASE_BITS-1:0] QUARTER_OFFSET = 32'h2000_0000;

   localparam logic [31:0] ATAN_TABLE [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic valid;
      logic err;
   } ctl_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] lat_index;
      logic [INDEX_BITS-1:0] lon_index;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] point_z;
      logic                         index_error;
      logic                         saturated;
   } rsp_type;

endpackage

[hw/rtl/sphere_grid_point_generator.sv]
// Top level of the sphere grid point generator.
// UV-sphere grid point generator. Each req transaction carries a latitude
// step and a longitude step; the block returns one rsp transaction with the
// point center + radius * (sin lat cos lon, sin lat sin lon, cos lat) in
// signed Q16.16, where lat = i/segments * pi and lon = j/segments * 2pi.
// Coordinates clip to 32 bits and raise saturated; a step above segments (or
// segments of zero) returns zero coordinates with index_error set. The block
// takes one transaction per clock unless rsp stalls, and passes it through
// 11 stages of the phase divider (three quotient bits each), 16 CORDIC
// micro-rotation stages plus one quadrant stage, and five stages of
// multiply, round, add and clip, the last of which is the output register.
// When rsp is stalled the whole pipeline holds and req_ready drops in the
// same cycle. Write the csr registers only while no transaction is in flight;
// the pipeline reads them live.
module sphere_grid_point_generator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sgp_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sgp_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [sgp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sgp_pkg::COORD_BITS-1:0]      csr_wdata
);
   import sgp_pkg::*;

   // Configuration registers.
   logic [RADIUS_BITS-1:0]       radius_ff;
   logic signed [COORD_BITS-1:0] center_x_ff;
   logic signed [COORD_BITS-1:0] center_y_ff;
   logic signed [COORD_BITS-1:0] center_z_ff;
   logic [INDEX_BITS-1:0]        segments_ff;

   logic                         enable;
   ctl_type                      in_ctl;
   ctl_type                      div_ctl;
   ctl_type                      cor_ctl;
   logic [PHASE_BITS-1:0]        lat_phase, lon_phase;
   logic signed [UNIT_BITS-1:0]  sin_lat, cos_lat, sin_lon, cos_lon;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= RADIUS_RESET;
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         segments_ff <= SEGMENTS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RADIUS:   radius_ff   <= csr_wdata[RADIUS_BITS-1:0];
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            CSR_CENTER_Z: center_z_ff <= csr_wdata;
            CSR_SEGMENTS: segments_ff <= csr_wdata[INDEX_BITS-1:0];
            default: ; // drop writes to unknown registers
         endcase
      end
   end

   // Advance every stage unless a finished result waits to be taken.
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   // Flag bad steps at the door; the flag rides along with the item.
   always_comb begin
      in_ctl.valid = req_valid;
      in_ctl.err   = (segments_ff == '0) || (req_data.lat_index > segments_ff)
                     || (req_data.lon_index > segments_ff);
   end

   sgp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .ctl_in    (in_ctl),
      .lat_index (req_data.lat_index),
      .lon_index (req_data.lon_index),
      .segments  (segments_ff),
      .ctl_out   (div_ctl),
      .lat_phase (lat_phase),
      .lon_phase (lon_phase)
   );

   sgp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .ctl_in    (div_ctl),
      .lat_phase (lat_phase),
      .lon_phase (lon_phase),
      .ctl_out   (cor_ctl),
      .sin_lat   (sin_lat),
      .cos_lat   (cos_lat),
      .sin_lon   (sin_lon),
      .cos_lon   (cos_lon)
   );

   sgp_place u_place (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .ctl_in    (cor_ctl),
      .sin_lat   (sin_lat),
      .cos_lat   (cos_lat),
      .sin_lon   (sin_lon),
      .cos_lon   (cos_lon),
      .radius    (radius_ff),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .center_z  (center_z_ff),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule

[hw/rtl/sgp_divider.sv]
// Pipelined divider that turns grid indexes into binary phases.
module sgp_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  sgp_pkg::ctl_type                ctl_in,
   input  logic [sgp_pkg::INDEX_BITS-1:0]  lat_index,
   input  logic [sgp_pkg::INDEX_BITS-1:0]  lon_index,
   input  logic [sgp_pkg::INDEX_BITS-1:0]  segments,
   output sgp_pkg::ctl_type                ctl_out,
   output logic [sgp_pkg::PHASE_BITS-1:0]  lat_phase,
   output logic [sgp_pkg::PHASE_BITS-1:0]  lon_phase
);
   import sgp_pkg::*;

   logic [REM_BITS-1:0] rlat_ff [DIV_STAGES];
   logic [REM_BITS-1:0] rlat_in [DIV_STAGES];
   logic [REM_BITS-1:0] rlon_ff [DIV_STAGES];
   logic [REM_BITS-1:0] rlon_in [DIV_STAGES];
   logic [DIV_BITS-1:0] qlat_ff [DIV_STAGES];
   logic [DIV_BITS-1:0] qlat_in [DIV_STAGES];
   logic [DIV_BITS-1:0] qlon_ff [DIV_STAGES];
   logic [DIV_BITS-1:0] qlon_in [DIV_STAGES];
   ctl_type             ctl_ff  [DIV_STAGES];

   logic [DIV_BITS-1:0] low_bits;
   logic [REM_BITS-1:0] divisor;

   // Dividend is idx * 2^33 (lat) or idx * 2^34 (lon) plus 2*segments;
   // its high part preloads the remainder, the low 33 bits shift in.
   assign low_bits = DIV_BITS'({segments, 1'b0});
   assign divisor  = REM_BITS'({segments, 2'b00});

   always_comb begin
      logic [REM_BITS-1:0] rl;
      logic [REM_BITS-1:0] ro;
      logic [DIV_BITS-1:0] ql;
      logic [DIV_BITS-1:0] qo;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            rl = REM_BITS'(lat_index);
            ro = REM_BITS'({lon_index, 1'b0});
            ql = '0;
            qo = '0;
         end else begin
            rl = rlat_ff[s-1];
            ro = rlon_ff[s-1];
            ql = qlat_ff[s-1];
            qo = qlon_ff[s-1];
         end
         for (int b = 0; b < DIV_STEP; b++) begin
            rl = {rl[REM_BITS-2:0], low_bits[DIV_BITS-1-s*DIV_STEP-b]};
            ro = {ro[REM_BITS-2:0], low_bits[DIV_BITS-1-s*DIV_STEP-b]};
            if (rl >= divisor) begin
               rl = rl - divisor;
               ql = {ql[DIV_BITS-2:0], 1'b1};
            end else begin
               ql = {ql[DIV_BITS-2:0], 1'b0};
            end
            if (ro >= divisor) begin
               ro = ro - divisor;
               qo = {qo[DIV_BITS-2:0], 1'b1};
            end else begin
               qo = {qo[DIV_BITS-2:0], 1'b0};
            end
         end
         rlat_in[s] = rl;
         rlon_in[s] = ro;
         qlat_in[s] = ql;
         qlon_in[s] = qo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            ctl_ff[s] <= '0;
         end
      end else if (enable) begin
         ctl_ff[0] <= ctl_in;
         for (int s = 1; s < DIV_STAGES; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            rlat_ff[s] <= rlat_in[s];
            rlon_ff[s] <= rlon_in[s];
            qlat_ff[s] <= qlat_in[s];
            qlon_ff[s] <= qlon_in[s];
         end
      end
   end

   // Full longitude gives 2^32 and wraps to zero by dropping the top bit.
   assign ctl_out   = ctl_ff[DIV_STAGES-1];
   assign lat_phase = qlat_ff[DIV_STAGES-1][PHASE_BITS-1:0];
   assign lon_phase = qlon_ff[DIV_STAGES-1][PHASE_BITS-1:0];

endmodule

[hw/rtl/sgp_cordic.sv]
// Two-lane pipelined CORDIC for the sine and cosine of both angles.
module sgp_cordic (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  enable,
   input  sgp_pkg::ctl_type                      ctl_in,
   input  logic [sgp_pkg::PHASE_BITS-1:0]        lat_phase,
   input  logic [sgp_pkg::PHASE_BITS-1:0]        lon_phase,
   output sgp_pkg::ctl_type                      ctl_out,
   output logic signed [sgp_pkg::UNIT_BITS-1:0]  sin_lat,
   output logic signed [sgp_pkg::UNIT_BITS-1:0]  cos_lat,
   output logic signed [sgp_pkg::UNIT_BITS-1:0]  sin_lon,
   output logic signed [sgp_pkg::UNIT_BITS-1:0]  cos_lon
);
   import sgp_pkg::*;

   logic signed [CORDIC_BITS-1:0] x_ff [CORDIC_STAGES][2];
   logic signed [CORDIC_BITS-1:0] x_in [CORDIC_STAGES][2];
   logic signed [CORDIC_BITS-1:0] y_ff [CORDIC_STAGES][2];
   logic signed [CORDIC_BITS-1:0] y_in [CORDIC_STAGES][2];
   logic signed [ANGLE_BITS-1:0]  z_ff [CORDIC_STAGES][2];
   logic signed [ANGLE_BITS-1:0]  z_in [CORDIC_STAGES][2];
   logic [1:0]                    q_ff [CORDIC_STAGES][2];
   logic [1:0]                    q_in [CORDIC_STAGES][2];
   ctl_type                       ctl_ff [CORDIC_STAGES];

   logic signed [UNIT_BITS-1:0] sin_ff [2];
   logic signed [UNIT_BITS-1:0] sin_in [2];
   logic signed [UNIT_BITS-1:0] cos_ff [2];
   logic signed [UNIT_BITS-1:0] cos_in [2];
   ctl_type                     out_ctl_ff;

   always_comb begin
      logic signed [CORDIC_BITS-1:0] x;
      logic signed [CORDIC_BITS-1:0] y;
      logic signed [CORDIC_BITS-1:0] xs;
      logic signed [CORDIC_BITS-1:0] ys;
      logic signed [ANGLE_BITS-1:0]  z;
      logic signed [ANGLE_BITS-1:0]  a;
      logic [PHASE_BITS-1:0]         ph;
      logic [PHASE_BITS-1:0]         sum;
      logic [1:0]                    q;
      for (int s = 0; s < CORDIC_STAGES; s++) begin
         for (int l = 0; l < 2; l++) begin
            ph  = (l == 0) ? lat_phase : lon_phase;
            sum = ph + QUARTER_OFFSET;
            if (s == 0) begin
               // Split off the quadrant; the residual lies in [-1/8, 1/8) turn.
               x = CORDIC_GAIN;
               y = '0;
               z = $signed(ANGLE_BITS'(sum[PHASE_BITS-3:0]))
                   - $signed(ANGLE_BITS'(QUARTER_OFFSET));
               q = sum[PHASE_BITS-1:PHASE_BITS-2];
            end else begin
               x = x_ff[s-1][l];
               y = y_ff[s-1][l];
               z = z_ff[s-1][l];
               q = q_ff[s-1][l];
            end
            xs = x >>> s;
            ys = y >>> s;
            a  = $signed(ANGLE_BITS'(ATAN_TABLE[s]));
            if (z >= 0) begin
               x = x - ys;
               y = y + xs;
               z = z - a;
            end else begin
               x = x + ys;
               y = y - xs;
               z = z + a;
            end
            x_in[s][l] = x;
            y_in[s][l] = y;
            z_in[s][l] = z;
            q_in[s][l] = q;
         end
      end
   end

   // Rotate the result back by the quadrant, exactly.
   always_comb begin
      logic signed [CORDIC_BITS-1:0] xf;
      logic signed [CORDIC_BITS-1:0] yf;
      for (int l = 0; l < 2; l++) begin
         xf = x_ff[CORDIC_STAGES-1][l];
         yf = y_ff[CORDIC_STAGES-1][l];
         case (q_ff[CORDIC_STAGES-1][l])
            2'd0: begin
               cos_in[l] = UNIT_BITS'(xf);
               sin_in[l] = UNIT_BITS'(yf);
            end
            2'd1: begin
               cos_in[l] = UNIT_BITS'(-yf);
               sin_in[l] = UNIT_BITS'(xf);
            end
            2'd2: begin
               cos_in[l] = UNIT_BITS'(-xf);
               sin_in[l] = UNIT_BITS'(-yf);
            end
            default: begin
               cos_in[l] = UNIT_BITS'(yf);
               sin_in[l] = UNIT_BITS'(-xf);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < CORDIC_STAGES; s++) begin
            ctl_ff[s] <= '0;
         end
         out_ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff[0] <= ctl_in;
         for (int s = 1; s < CORDIC_STAGES; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
         out_ctl_ff <= ctl_ff[CORDIC_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < CORDIC_STAGES; s++) begin
            for (int l = 0; l < 2; l++) begin
               x_ff[s][l] <= x_in[s][l];
               y_ff[s][l] <= y_in[s][l];
               z_ff[s][l] <= z_in[s][l];
               q_ff[s][l] <= q_in[s][l];
            end
         end
         for (int l = 0; l < 2; l++) begin
            sin_ff[l] <= sin_in[l];
            cos_ff[l] <= cos_in[l];
         end
      end
   end

   assign ctl_out = out_ctl_ff;
   assign sin_lat = sin_ff[0];
   assign cos_lat = cos_ff[0];
   assign sin_lon = sin_ff[1];
   assign cos_lon = cos_ff[1];

endmodule

[hw/rtl/sgp_place.sv]
// Scale the unit vector by the radius, add the center and clip to 32 bits.
module sgp_place (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  enable,
   input  sgp_pkg::ctl_type                      ctl_in,
   input  logic signed [sgp_pkg::UNIT_BITS-1:0]  sin_lat,
   input  logic signed [sgp_pkg::UNIT_BITS-1:0]  cos_lat,
   input  logic signed [sgp_pkg::UNIT_BITS-1:0]  sin_lon,
   input  logic signed [sgp_pkg::UNIT_BITS-1:0]  cos_lon,
   input  logic [sgp_pkg::RADIUS_BITS-1:0]       radius,
   input  logic signed [sgp_pkg::COORD_BITS-1:0] center_x,
   input  logic signed [sgp_pkg::COORD_BITS-1:0] center_y,
   input  logic signed [sgp_pkg::COORD_BITS-1:0] center_z,
   output logic                                  rsp_valid,
   output sgp_pkg::rsp_type                      rsp
);
   import sgp_pkg::*;

   localparam int PROD_BITS = 2 * UNIT_BITS;
   localparam int SUM_BITS  = COORD_BITS + 4;

   function automatic logic signed [PROD_BITS-31:0] round_q30(
      input logic signed [PROD_BITS-1:0] v);
      logic signed [PROD_BITS-1:0] t;
      t = v + (PROD_BITS'(1) <<< 29);
      return t[PROD_BITS-1:30];
   endfunction

   function automatic logic [COORD_BITS:0] clip(input logic signed [SUM_BITS-1:0] v);
      logic over;
      over = (v[SUM_BITS-1:COORD_BITS-1] != '0) && (v[SUM_BITS-1:COORD_BITS-1] != '1);
      if (over) begin
         return {1'b1, v[SUM_BITS-1], {(COORD_BITS-1){~v[SUM_BITS-1]}}};
      end
      return {1'b0, v[COORD_BITS-1:0]};
   endfunction

   ctl_type                     ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff;
   logic signed [PROD_BITS-1:0] px1_ff, py1_ff;
   logic signed [UNIT_BITS-1:0] uz1_ff;
   logic signed [UNIT_BITS-1:0] ux2_ff, uy2_ff, uz2_ff;
   logic signed [PROD_BITS-1:0] mx3_ff, my3_ff, mz3_ff;
   logic signed [SUM_BITS-1:0]  sx4_ff, sy4_ff, sz4_ff;
   logic                        valid5_ff;
   rsp_type                     rsp5_ff;
   rsp_type                     rsp5_in;
   logic [COORD_BITS:0]         cx, cy, cz;

   always_comb begin
      cx = clip(sx4_ff);
      cy = clip(sy4_ff);
      cz = clip(sz4_ff);
      if (ctl4_ff.err) begin
         rsp5_in = '0;
         rsp5_in.index_error = 1'b1;
      end else begin
         rsp5_in.point_x     = cx[COORD_BITS-1:0];
         rsp5_in.point_y     = cy[COORD_BITS-1:0];
         rsp5_in.point_z     = cz[COORD_BITS-1:0];
         rsp5_in.index_error = 1'b0;
         rsp5_in.saturated   = cx[COORD_BITS] | cy[COORD_BITS] | cz[COORD_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff   <= '0;
         ctl2_ff   <= '0;
         ctl3_ff   <= '0;
         ctl4_ff   <= '0;
         valid5_ff <= 1'b0;
      end else if (enable) begin
         ctl1_ff   <= ctl_in;
         ctl2_ff   <= ctl1_ff;
         ctl3_ff   <= ctl2_ff;
         ctl4_ff   <= ctl3_ff;
         valid5_ff <= ctl4_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         px1_ff  <= sin_lat * cos_lon;
         py1_ff  <= sin_lat * sin_lon;
         uz1_ff  <= cos_lat;
         ux2_ff  <= UNIT_BITS'(round_q30(px1_ff));
         uy2_ff  <= UNIT_BITS'(round_q30(py1_ff));
         uz2_ff  <= uz1_ff;
         mx3_ff  <= $signed({1'b0, radius}) * ux2_ff;
         my3_ff  <= $signed({1'b0, radius}) * uy2_ff;
         mz3_ff  <= $signed({1'b0, radius}) * uz2_ff;
         sx4_ff  <= SUM_BITS'(center_x) + SUM_BITS'(round_q30(mx3_ff));
         sy4_ff  <= SUM_BITS'(center_y) + SUM_BITS'(round_q30(my3_ff));
         sz4_ff  <= SUM_BITS'(center_z) + SUM_BITS'(round_q30(mz3_ff));
         rsp5_ff <= rsp5_in;
      end
   end

   assign rsp_valid = valid5_ff;
   assign rsp       = rsp5_ff;

endmodule

[hw/rtl/sgp_checker.sv]
// Port-level checker for the sphere grid point generator, bound to the top.
`include "sphere_grid_point_generator_defines.svh"

module sgp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input sgp_pkg::req_type                    req_data,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input sgp_pkg::rsp_type                    rsp_data
);

   `SGP_ASSERT(a_req_hold, req_valid && !req_ready |=> req_valid && $stable(req_data), "req dropped or changed while waiting")

   `SGP_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp dropped or changed while stalled")

   `SGP_ASSERT(a_err_zero, rsp_valid && rsp_data.index_error |-> rsp_data.point_x == 0 && rsp_data.point_y == 0 && rsp_data.point_z == 0 && !rsp_data.saturated, "index error with nonzero result")

   `SGP_ASSERT(a_ready_stall, !req_ready |-> rsp_valid && !rsp_ready, "req_ready low without output stall")

   `SGP_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "rsp_valid after reset")

endmodule

bind sphere_grid_point_generator sgp_checker u_sgp_checker (.*);

[tb/sv/sphere_grid_point_generator_test.sv]
// Self-checking testbench for the sphere grid point generator.
module sphere_grid_point_generator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sgp_pkg::*;

   // Register index with no register behind it; writes to it must be ignored.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;
   localparam rsp_type ERR_POINT = '{point_x: '0, point_y: '0, point_z: '0,
                                     index_error: 1'b1, saturated: 1'b0};
   localparam int DRAIN_CYCLES = 40;     // pipeline depth is 33
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS = 183;

   typedef struct {
      bit                        is_csr;
      logic [CSR_INDEX_BITS-1:0] idx;
      logic [31:0]               wdata;
      logic [INDEX_BITS-1:0]     lat;
      logic [INDEX_BITS-1:0]     lon;
      bit                        typed;
      rsp_type                   exp;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [COORD_BITS-1:0] csr_wdata = '0;

   sphere_grid_point_generator u_top (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   always #4 clock = ~clock;

   // Shadow copy of the configuration registers.
   longint unsigned radius_q16 = 65536;
   longint center_q16 [3] = '{0, 0, 0};
   longint unsigned grid_segments = 200;

   rsp_type pending_points [$];
   bit quiet = 1'b0;          // no idling on either side in the last part
   bit next_typed = 1'b0;     // the transaction in flight carries a typed answer
   rsp_type next_exp;
   int failures = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   row_type rows [$];

   // Binary phase of idx/den of a full turn, rounded half up, wrapped to 32 bits.
   function automatic logic [31:0] grid_phase(longint unsigned idx, longint unsigned den);
      longint unsigned p;
      p = ((idx << 33) + den) / (2 * den);
      return p[31:0];
   endfunction

   // Fixed-length rotation CORDIC; outputs Q2.30 sine and cosine.
   task automatic cordic_sin_cos(input logic [31:0] phase, output longint sn,
                                 output longint cs);
      longint unsigned qraw;
      longint z, x, y, xs, ys;
      logic [1:0] q;
      qraw = ({32'd0, phase} + 64'h2000_0000) >> 30;
      z = longint'({32'd0, phase}) - longint'(qraw << 30);
      q = qraw[1:0];
      x = 652032874;
      y = 0;
      for (int k = 0; k < CORDIC_STAGES; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - longint'({32'd0, ATAN_TABLE[k]});
         end else begin
            x = x + ys; y = y - xs; z = z + longint'({32'd0, ATAN_TABLE[k]});
         end
      end
      case (q)
         2'd0: begin cs = x; sn = y; end
         2'd1: begin cs = -y; sn = x; end
         2'd2: begin cs = -x; sn = -y; end
         default: begin cs = y; sn = -x; end
      endcase
   endtask

   function automatic longint round_q30(longint v);
      return (v + (longint'(1) << 29)) >>> 30;
   endfunction

   // Scale a unit coordinate by the radius, add the center and clip.
   function automatic logic [31:0] place_coord(longint center, longint unit, ref bit sat);
      longint v;
      v = center + round_q30(longint'(radius_q16) * unit);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         v = 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         sat = 1'b1;
         v = -64'sd2147483648;
      end
      return v[31:0];
   endfunction

   task automatic grid_point(input logic [INDEX_BITS-1:0] lat, input logic [INDEX_BITS-1:0] lon,
                             output rsp_type pt);
      longint slat, clat, slon, clon;
      bit sat;
      sat = 1'b0;
      if (grid_segments == 0 || lat > grid_segments || lon > grid_segments) begin
         pt = ERR_POINT;
      end else begin
         cordic_sin_cos(grid_phase(lat, 2 * grid_segments), slat, clat);
         cordic_sin_cos(grid_phase(lon, grid_segments), slon, clon);
         pt.point_x = place_coord(center_q16[0], round_q30(slat * clon), sat);
         pt.point_y = place_coord(center_q16[1], round_q30(slat * slon), sat);
         pt.point_z = place_coord(center_q16[2], clat, sat);
         pt.index_error = 1'b0;
         pt.saturated = sat;
      end
   endtask

   // Monitor: predict on every accepted request, check every accepted response.
   always @(posedge clock) begin
      rsp_type exp;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (next_typed) exp = next_exp;
            else grid_point(req_data.lat_index, req_data.lon_index, exp);
            pending_points = {pending_points, exp};
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_points.size() == 0) begin
               $display("%0t: response with nothing pending: %h", $realtime, rsp_data);
               failures++;
            end else begin
               exp = pending_points.pop_front();
               if (rsp_data.point_x !== exp.point_x || rsp_data.point_y !== exp.point_y ||
                   rsp_data.point_z !== exp.point_z ||
                   rsp_data.index_error !== exp.index_error ||
                   rsp_data.saturated !== exp.saturated) begin
                  $display("%0t: mismatch expected x=%h y=%h z=%h err=%b sat=%b", $realtime,
                           exp.point_x, exp.point_y, exp.point_z, exp.index_error,
                           exp.saturated);
                  $display("%0t:          actual   x=%h y=%h z=%h err=%b sat=%b", $realtime,
                           rsp_data.point_x, rsp_data.point_y, rsp_data.point_z,
                           rsp_data.index_error, rsp_data.saturated);
                  failures++;
               end
            end
         end
         // Watchdog: count cycles without any transaction.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $realtime);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Response side: stall in random bursts, never in the quiet part.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Write a register once the pipeline has drained. Called at a falling edge.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [31:0] data);
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_RADIUS:   radius_q16 = data[30:0];
         CSR_CENTER_X: center_q16[0] = longint'(signed'(data));
         CSR_CENTER_Y: center_q16[1] = longint'(signed'(data));
         CSR_CENTER_Z: center_q16[2] = longint'(signed'(data));
         CSR_SEGMENTS: grid_segments = data[INDEX_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Present one request and hold it until accepted; return at a falling edge.
   task automatic send_point(input logic [INDEX_BITS-1:0] lat, input logic [INDEX_BITS-1:0] lon,
                             input bit typed, input rsp_type exp);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      next_typed = typed;
      next_exp = exp;
      req_valid <= 1'b1;
      req_data <= '{lat_index: lat, lon_index: lon};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic row_type csr_row(logic [CSR_INDEX_BITS-1:0] idx, logic [31:0] data);
      return '{is_csr: 1'b1, idx: idx, wdata: data, lat: '0, lon: '0, typed: 1'b0,
               exp: ERR_POINT};
   endfunction

   function automatic row_type item_row(logic [INDEX_BITS-1:0] lat, logic [INDEX_BITS-1:0] lon,
                                        bit typed);
      return '{is_csr: 1'b0, idx: '0, wdata: '0, lat: lat, lon: lon, typed: typed,
               exp: ERR_POINT};
   endfunction

   // Pick a random value for one register, often an extreme.
   function automatic logic [31:0] random_reg(logic [CSR_INDEX_BITS-1:0] idx);
      int pick;
      pick = $urandom_range(0, 9);
      case (idx)
         CSR_RADIUS:
            return (pick == 0) ? 32'h7FFF_FFFF : (pick == 1) ? 32'd0 :
                   (pick < 5) ? 32'd65536 << $urandom_range(0, 12) : $urandom;
         CSR_SEGMENTS:
            return (pick == 0) ? 32'd1023 : (pick == 1) ? 32'd1 :
                   (pick == 2) ? $urandom : 32'($urandom_range(1, 24));
         default:
            return (pick == 0) ? 32'h7FFF_FFFF : (pick == 1) ? 32'h8000_0000 :
                   (pick < 6) ? 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000 :
                   $urandom;
      endcase
   endfunction

   initial begin
      logic [INDEX_BITS-1:0] lat, lon;

      // Directed table: reset values, bad indices, saturation, segment extremes.
      rows = {rows, item_row(0, 0, 0)};
      rows = {rows, item_row(100, 0, 0)};
      rows = {rows, item_row(200, 200, 0)};
      rows = {rows, item_row(100, 50, 0)};
      rows = {rows, item_row(201, 0, 1)};
      rows = {rows, item_row(0, 201, 1)};
      rows = {rows, item_row(1023, 1023, 1)};
      rows = {rows, csr_row(CSR_RADIUS, 32'h7FFF_FFFF)};
      rows = {rows, csr_row(CSR_CENTER_X, 32'h7FFF_FFFF)};
      rows = {rows, csr_row(CSR_CENTER_Y, 32'h8000_0000)};
      rows = {rows, csr_row(CSR_CENTER_Z, 32'h8000_0000)};
      rows = {rows, item_row(100, 0, 0)};
      rows = {rows, item_row(100, 100, 0)};
      rows = {rows, item_row(0, 0, 0)};
      rows = {rows, item_row(200, 0, 0)};
      rows = {rows, csr_row(CSR_SEGMENTS, 32'd1)};
      rows = {rows, item_row(0, 0, 0)};
      rows = {rows, item_row(1, 1, 0)};
      rows = {rows, item_row(1, 0, 0)};
      rows = {rows, item_row(2, 0, 1)};
      rows = {rows, csr_row(CSR_SEGMENTS, 32'hFFFF_FFFF)};
      rows = {rows, item_row(1023, 1023, 0)};
      rows = {rows, item_row(512, 256, 0)};
      rows = {rows, item_row(1, 1022, 0)};
      rows = {rows, csr_row(CSR_SEGMENTS, 32'd0)};
      rows = {rows, item_row(0, 0, 1)};
      rows = {rows, csr_row(CSR_UNUSED, 32'h0001_2345)};
      rows = {rows, item_row(5, 5, 1)};

      // Hold reset at first, then release it at a falling edge.
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (rows[n]) begin
         if (rows[n].is_csr) write_reg(rows[n].idx, rows[n].wdata);
         else send_point(rows[n].lat, rows[n].lon, rows[n].typed, rows[n].exp);
      end

      // Random phases; each begins by draining and rewriting every register.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         for (int r = 0; r <= CSR_SEGMENTS; r++) begin
            write_reg(CSR_INDEX_BITS'(r), random_reg(CSR_INDEX_BITS'(r)));
         end
         if ($urandom_range(0, 3) == 0) write_reg(3'($urandom_range(5, 7)), $urandom);
         quiet = (ph == RANDOM_PHASES - 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 85) begin
               lat = INDEX_BITS'($urandom_range(0, 32'(grid_segments)));
               lon = INDEX_BITS'($urandom_range(0, 32'(grid_segments)));
            end else begin
               lat = INDEX_BITS'($urandom);
               lon = INDEX_BITS'($urandom);
            end
            send_point(lat, lon, 1'b0, ERR_POINT);
         end
      end

      // Drain, then allow the pipeline latency before judging.
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0 && pending_points.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/sgp_pkg.sv
hw/rtl/sgp_divider.sv
hw/rtl/sgp_cordic.sv
hw/rtl/sgp_place.sv
hw/rtl/sphere_grid_point_generator.sv
hw/rtl/sgp_checker.sv
tb/sv/sphere_grid_point_generator_test.sv
